[rtl/button_command_record_playback_defines.svh]
// assertion macros used by the recorder core
`ifndef BUTTON_COMMAND_RECORD_PLAYBACK_DEFINES_SVH
`define BUTTON_COMMAND_RECORD_PLAYBACK_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BCRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcrp assertion failed");

// next-cycle implication, disabled while reset is low
`define BCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcrp assertion failed");

`endif

[rtl/bcrp_pkg.sv]
// shared types and constants for the button command recorder
`default_nettype none

package bcrp_pkg;

	localparam int STORE_DEPTH = 10;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int SLOT_W = CNT_W + 2;
	localparam int OUT_CNT_W = 4;
	localparam int SPAN_W = 17;
	localparam int DB_W = 13;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// command codes held in the store
	localparam logic [2:0] CODE_NONE = 3'd0;
	localparam logic [2:0] CODE_LEFT = 3'd1;
	localparam logic [2:0] CODE_RIGHT = 3'd2;
	localparam logic [2:0] CODE_UP = 3'd3;
	localparam logic [2:0] CODE_DOWN = 3'd4;

	// register indexes
	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_FRAME = 3'd1;
	localparam logic [2:0] REG_WIDTH1 = 3'd2;
	localparam logic [2:0] REG_WIDTH2 = 3'd3;
	localparam logic [2:0] REG_WIDTH3 = 3'd4;
	localparam logic [2:0] REG_WIDTH4 = 3'd5;

	// reset values of the registers
	localparam logic [9:0] DEBOUNCE_RST = 10'd20;
	localparam logic [15:0] FRAME_RST = 16'd500;
	localparam logic [15:0] WIDTH1_RST = 16'd50;
	localparam logic [15:0] WIDTH2_RST = 16'd25;
	localparam logic [15:0] WIDTH3_RST = 16'd75;
	localparam logic [15:0] WIDTH4_RST = 16'd100;

	typedef struct packed {
		logic btn_left;
		logic btn_right;
		logic btn_up;
		logic btn_down;
		logic btn_clear;
		logic btn_pause;
		logic btn_go;
	} in_t;

	typedef struct packed {
		logic                 pulse_out;
		logic                 playing;
		logic [OUT_CNT_W-1:0] recorded_count;
		logic [OUT_CNT_W-1:0] played_count;
	} out_t;

	typedef struct packed {
		logic [9:0]       debounce_ticks;
		logic [15:0]      frame_ticks;
		logic [3:0][15:0] width_code;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/bcrp_regs.sv]
// configuration registers behind the apb-style port
`default_nettype none

module bcrp_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bcrp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bcrp_pkg::DATA_W-1:0] pwdata,
	output logic      [bcrp_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output bcrp_pkg::cfg_t                   cfg
);
	import bcrp_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.frame_ticks <= FRAME_RST;
			cfg_q.width_code[0] <= WIDTH1_RST;
			cfg_q.width_code[1] <= WIDTH2_RST;
			cfg_q.width_code[2] <= WIDTH3_RST;
			cfg_q.width_code[3] <= WIDTH4_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEBOUNCE: cfg_q.debounce_ticks <= pwdata[9:0];
				REG_FRAME:    cfg_q.frame_ticks <= pwdata[15:0];
				REG_WIDTH1:   cfg_q.width_code[0] <= pwdata[15:0];
				REG_WIDTH2:   cfg_q.width_code[1] <= pwdata[15:0];
				REG_WIDTH3:   cfg_q.width_code[2] <= pwdata[15:0];
				REG_WIDTH4:   cfg_q.width_code[3] <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE: prdata = DATA_W'(cfg_q.debounce_ticks);
			REG_FRAME:    prdata = DATA_W'(cfg_q.frame_ticks);
			REG_WIDTH1:   prdata = DATA_W'(cfg_q.width_code[0]);
			REG_WIDTH2:   prdata = DATA_W'(cfg_q.width_code[1]);
			REG_WIDTH3:   prdata = DATA_W'(cfg_q.width_code[2]);
			REG_WIDTH4:   prdata = DATA_W'(cfg_q.width_code[3]);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/bcrp_core.sv]
// loop pass, command store and busy span tracking for one tick
`default_nettype none

`include "button_command_record_playback_defines.svh"

module bcrp_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  bcrp_pkg::in_t       levels,
	input  bcrp_pkg::cfg_t      cfg,
	output bcrp_pkg::out_t      result
);
	import bcrp_pkg::*;

	logic [2:0]        store_q [STORE_DEPTH];
	logic [CNT_W-1:0]  rec_q;
	logic [CNT_W-1:0]  play_q;
	logic              mode_q;
	logic [6:0]        prev_q;
	logic [SPAN_W-1:0] busy_elapsed_q;
	logic [SPAN_W-1:0] busy_len_q;
	logic [SPAN_W-1:0] pulse_begin_q;
	logic [SPAN_W-1:0] pulse_end_q;

	logic [2:0]        store_n [STORE_DEPTH];
	logic [CNT_W-1:0]  rec_n;
	logic [CNT_W-1:0]  play_n;
	logic              mode_n;
	logic [6:0]        prev_n;
	logic [SPAN_W-1:0] begin_n;
	logic [SPAN_W-1:0] end_n;
	logic [SPAN_W-1:0] len_n;

	logic              pass;
	logic [6:0]        lv;
	logic [6:0]        press;
	logic [6:0]        diff;
	logic              clr;
	logic [CNT_W-1:0]  rec_base;
	logic [CNT_W-1:0]  play_base;
	logic              recording;
	logic              replaying;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] slot_d [4];
	logic [3:0]        wr;
	logic [2:0]        code;
	logic [2:0]        edges;
	logic [DB_W-1:0]   db;
	logic [15:0]       width;
	logic [15:0]       high;
	logic [15:0]       frame;
	logic              has_frame;
	logic [SPAN_W-1:0] el;
	logic [SPAN_W-1:0] el_inc;
	logic [SPAN_W-1:0] b_use;
	logic [SPAN_W-1:0] e_use;
	logic [SPAN_W-1:0] len_use;
	logic              pulse;

	assign pass = (busy_len_q == '0);
	assign lv = {levels.btn_go, levels.btn_pause, levels.btn_clear, levels.btn_down,
		levels.btn_up, levels.btn_right, levels.btn_left};
	assign press = prev_q & ~lv;
	assign diff = prev_q ^ lv;
	assign clr = press[4];

	// mode and base counts after the clear, pause and go presses
	always_comb begin
		if (press[6])
			mode_n = 1'b1;
		else if (press[5] || clr)
			mode_n = 1'b0;
		else
			mode_n = mode_q;
		rec_base = clr ? '0 : rec_q;
		play_base = clr ? '0 : play_q;
		recording = !mode_n && (rec_base < CNT_W'(STORE_DEPTH));
		replaying = mode_n && (play_base < CNT_W'(STORE_DEPTH));
	end

	// direction presses append in button order while room remains
	always_comb begin
		slot = SLOT_W'(rec_base);
		for (int d = 0; d < 4; d++) begin
			slot_d[d] = slot;
			wr[d] = recording && press[d] && (slot < SLOT_W'(STORE_DEPTH));
			if (wr[d])
				slot = slot + SLOT_W'(1);
		end
		rec_n = CNT_W'(slot);
		for (int e = 0; e < STORE_DEPTH; e++) begin
			store_n[e] = clr ? CODE_NONE : store_q[e];
			for (int d = 0; d < 4; d++) begin
				if (wr[d] && (slot_d[d] == SLOT_W'(e)))
					store_n[e] = 3'(d + 1);
			end
		end
		prev_n = {lv[6:4], recording ? lv[3:0] : prev_q[3:0]};
	end

	// playback read and frame timing
	always_comb begin
		code = (replaying && !clr) ? store_q[play_base[IDX_W-1:0]] : CODE_NONE;
		play_n = replaying ? play_base + CNT_W'(1) : play_base;
		has_frame = 1'b1;
		case (code)
			CODE_LEFT:  width = cfg.width_code[0];
			CODE_RIGHT: width = cfg.width_code[1];
			CODE_UP:    width = cfg.width_code[2];
			CODE_DOWN:  width = cfg.width_code[3];
			default: begin
				width = '0;
				has_frame = 1'b0;
			end
		endcase
		frame = has_frame ? cfg.frame_ticks : '0;
		high = (width > frame) ? frame : width;
		edges = 3'(diff[4]) + 3'(diff[5]) + 3'(diff[6]);
		if (recording)
			edges = edges + 3'(diff[0]) + 3'(diff[1]) + 3'(diff[2]) + 3'(diff[3]);
		db = DB_W'(edges) * DB_W'(cfg.debounce_ticks);
		begin_n = SPAN_W'(db);
		end_n = SPAN_W'(db) + SPAN_W'(high);
		len_n = SPAN_W'(db) + SPAN_W'(frame);
	end

	// position within the busy span for this tick
	always_comb begin
		el = pass ? '0 : busy_elapsed_q;
		b_use = pass ? begin_n : pulse_begin_q;
		e_use = pass ? end_n : pulse_end_q;
		len_use = pass ? len_n : busy_len_q;
		pulse = (el >= b_use) && (el < e_use);
		el_inc = el + SPAN_W'(1);
	end

	always_comb begin
		result.pulse_out = pulse;
		result.playing = pass ? mode_n : mode_q;
		result.recorded_count = OUT_CNT_W'(pass ? rec_n : rec_q);
		result.played_count = OUT_CNT_W'(pass ? play_n : play_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < STORE_DEPTH; e++)
				store_q[e] <= CODE_NONE;
			rec_q <= '0;
			play_q <= '0;
			mode_q <= 1'b0;
			prev_q <= '0;
			busy_elapsed_q <= '0;
			busy_len_q <= '0;
			pulse_begin_q <= '0;
			pulse_end_q <= '0;
		end else if (step) begin
			if (pass) begin
				store_q <= store_n;
				rec_q <= rec_n;
				play_q <= play_n;
				mode_q <= mode_n;
				prev_q <= prev_n;
				pulse_begin_q <= begin_n;
				pulse_end_q <= end_n;
			end
			if (el_inc >= len_use) begin
				busy_elapsed_q <= '0;
				busy_len_q <= '0;
			end else begin
				busy_elapsed_q <= el_inc;
				busy_len_q <= len_use;
			end
		end
	end

	`BCRP_ASSERT_IMPL(a_elapsed_in_span, clk, arst_n, busy_len_q != '0, busy_elapsed_q < busy_len_q)
	`BCRP_ASSERT_IMPL(a_counts_bounded, clk, arst_n, 1'b1, (rec_q <= CNT_W'(STORE_DEPTH)) && (play_q <= CNT_W'(STORE_DEPTH)))
	`BCRP_ASSERT_IMPL(a_pulse_order, clk, arst_n, busy_len_q != '0, pulse_end_q >= pulse_begin_q)
	`BCRP_ASSERT_NEXT(a_busy_holds_state, clk, arst_n, step && !pass, $stable(rec_q) && $stable(play_q) && $stable(mode_q))

endmodule

`default_nettype wire

[rtl/button_command_record_playback.sv]
// top level: tick input register, loop pass core and drive result register
//
// channel | valid      | stall       | word
// --------+------------+-------------+-------------------------------
// tick    | tick_valid | tick_stall  | tick  (seven active-low buttons)
// drive   | drive_valid| drive_stall | drive (pulse, mode, counts)
//
// one tick word is taken every cycle while tick_stall is low; it goes into the tick register, then the drive register
// the pass logic and busy span update sit between the tick register and the drive register
// tick_stall rises only while both registers are full and drive_stall is high
// reset clears the store, counts, mode, previous levels and busy span at once
`default_nettype none

module button_command_record_playback (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        tick_valid,
	output logic                             tick_stall,
	input  bcrp_pkg::in_t                    tick,
	output logic                             drive_valid,
	input  wire logic                        drive_stall,
	output bcrp_pkg::out_t                   drive,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bcrp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bcrp_pkg::DATA_W-1:0] pwdata,
	output logic      [bcrp_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);
	import bcrp_pkg::*;

	cfg_t  cfg;
	in_t   tick_s1;
	logic  valid_s1;
	out_t  result;
	out_t  drive_q;
	logic  drive_valid_q;
	logic  advance;

	bcrp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcrp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.levels (tick_s1),
		.cfg    (cfg),
		.result (result)
	);

	// the stage moves when the drive register is empty or being emptied
	assign advance = valid_s1 && (!drive_valid_q || !drive_stall);
	assign tick_stall = valid_s1 && !advance;
	assign drive_valid = drive_valid_q;
	assign drive = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			drive_valid_q <= 1'b0;
		end else begin
			if (!tick_stall)
				valid_s1 <= tick_valid;
			if (advance)
				drive_valid_q <= 1'b1;
			else if (!drive_stall)
				drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall)
			tick_s1 <= tick;
		if (advance)
			drive_q <= result;
	end

endmodule

`default_nettype wire

[tb/sv/button_command_record_playback_test.sv]
// testbench for the button command recorder: tick stream, drive checks and register port
`default_nettype none

module button_command_record_playback_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bcrp_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;

	// keys in the order of the tick word, a set bit means the button is held down
	localparam logic [6:0] K_LEFT = 7'h40;
	localparam logic [6:0] K_RIGHT = 7'h20;
	localparam logic [6:0] K_UP = 7'h10;
	localparam logic [6:0] K_DOWN = 7'h08;
	localparam logic [6:0] K_CLEAR = 7'h04;
	localparam logic [6:0] K_PAUSE = 7'h02;
	localparam logic [6:0] K_GO = 7'h01;
	localparam logic [6:0] K_NONE = 7'h00;

	// positions in the level vector, directions take bits 0 to 3
	localparam int LV_CLEAR = 4;
	localparam int LV_PAUSE = 5;
	localparam int LV_GO = 6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                tick_valid = 1'b0;
	logic                tick_stall;
	in_t                 tick = '1;
	logic                drive_valid;
	logic                drive_stall = 1'b0;
	out_t                drive;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// recorder state as the drive words should reflect it
	logic [2:0]  cmd_store[STORE_DEPTH];
	int unsigned rec_cnt;
	int unsigned play_cnt;
	bit          playback_mode;
	logic [6:0]  last_levels;
	int unsigned span_elapsed;
	int unsigned span_length;
	int unsigned high_from;
	int unsigned high_until;
	int unsigned lockout_ticks;
	int unsigned frame_len;
	int unsigned code_width[4];

	out_t        drive_q[$];
	int          err_cnt = 0;
	bit          idling = 1'b1;
	bit          hold_req = 1'b0;

	button_command_record_playback DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.drive(drive),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	function automatic string drive_text(input out_t d);
		return $sformatf("pulse=%0d playing=%0d recorded=%0d played=%0d",
			d.pulse_out, d.playing, d.recorded_count, d.played_count);
	endfunction

	function automatic in_t pressing(input logic [6:0] keys);
		return ~keys;
	endfunction

	function automatic logic [2:0] dir_code(input int d);
		case (d)
			0: return CODE_LEFT;
			1: return CODE_RIGHT;
			2: return CODE_UP;
			default: return CODE_DOWN;
		endcase
	endfunction

	function automatic int unsigned high_ticks(input logic [2:0] code);
		case (code)
			CODE_LEFT: return code_width[0];
			CODE_RIGHT: return code_width[1];
			CODE_UP: return code_width[2];
			CODE_DOWN: return code_width[3];
			default: return 0;
		endcase
	endfunction

	// one tick: a loop pass when no busy span is running, then the drive level of this tick
	function automatic out_t predict_drive(input in_t w);
		logic [6:0]  lv;
		logic [6:0]  pv;
		logic [6:0]  nxt;
		logic [2:0]  code;
		int unsigned edges;
		int unsigned frame;
		int unsigned high;
		int          d;
		out_t        r;
		lv = {w.btn_go, w.btn_pause, w.btn_clear, w.btn_down, w.btn_up, w.btn_right,
			w.btn_left};
		if (span_length == 0) begin
			pv = last_levels;
			edges = 0;
			frame = 0;
			high = 0;
			if (pv[LV_CLEAR] && !lv[LV_CLEAR]) begin
				foreach (cmd_store[i]) cmd_store[i] = CODE_NONE;
				rec_cnt = 0;
				play_cnt = 0;
				playback_mode = 1'b0;
				edges++;
			end
			if (pv[LV_PAUSE] && !lv[LV_PAUSE]) begin
				playback_mode = 1'b0;
				edges++;
			end
			if (pv[LV_GO] && !lv[LV_GO]) begin
				playback_mode = 1'b1;
				edges++;
			end
			for (d = LV_CLEAR; d <= LV_GO; d++) begin
				if (!pv[d] && lv[d]) edges++;
			end
			nxt = {lv[6:4], pv[3:0]};
			if (!playback_mode && rec_cnt < STORE_DEPTH) begin
				for (d = 0; d < 4; d++) begin
					if (pv[d] && !lv[d]) begin
						// store may fill in the middle of a pass, the edge still counts
						if (rec_cnt < STORE_DEPTH) begin
							cmd_store[rec_cnt] = dir_code(d);
							rec_cnt++;
						end
						edges++;
					end
				end
				for (d = 0; d < 4; d++) begin
					if (!pv[d] && lv[d]) edges++;
				end
				nxt[3:0] = lv[3:0];
			end else if (playback_mode && play_cnt < STORE_DEPTH) begin
				code = cmd_store[play_cnt];
				play_cnt++;
				if (code != CODE_NONE) begin
					frame = frame_len;
					high = high_ticks(code);
					if (high > frame) high = frame;
				end
			end
			last_levels = nxt;
			high_from = edges * lockout_ticks;
			high_until = high_from + high;
			span_length = high_from + frame;
			span_elapsed = 0;
		end
		r.pulse_out = (span_elapsed >= high_from && span_elapsed < high_until);
		r.playing = playback_mode;
		r.recorded_count = rec_cnt[OUT_CNT_W-1:0];
		r.played_count = play_cnt[OUT_CNT_W-1:0];
		span_elapsed++;
		if (span_elapsed >= span_length) begin
			span_elapsed = 0;
			span_length = 0;
		end
		return r;
	endfunction

	task automatic send_tick(input in_t w);
		if (idling && $urandom_range(7) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick <= w;
		do @(posedge clk); while (tick_stall);
		drive_q.push_back(predict_drive(w));
	endtask

	// ticks during a busy span are ignored, so fill them with noise and land w on a pass
	task automatic apply_pass(input in_t w);
		while (span_length != 0) begin
			send_tick(pressing(7'($urandom_range(127))));
		end
		send_tick(w);
	endtask

	function automatic in_t pick_levels();
		logic [6:0] keys;
		int         r;
		keys = K_NONE;
		r = $urandom_range(99);
		if (r < 8) begin
			keys = 7'($urandom_range(127));
		end else if (r < 38) begin
			keys = K_NONE;
		end else if (r < 72) begin
			// shifting the left key down walks through right, up and down
			keys = K_LEFT >> $urandom_range(3);
			if ($urandom_range(3) == 0) keys |= K_LEFT >> $urandom_range(3);
		end else if (r < 78) begin
			keys = K_CLEAR;
		end else if (r < 89) begin
			keys = K_PAUSE;
		end else begin
			keys = K_GO;
		end
		return pressing(keys);
	endfunction

	task automatic run_random(input int passes);
		repeat (passes) apply_pass(pick_levels());
	endtask

	task automatic drain_drive();
		tick_valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_access(input logic [2:0] idx, input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input logic [2:0] idx, input logic [31:0] want);
		logic [31:0] got;
		reg_access(idx, 1'b0, 32'd0, got);
		if (got !== want) begin
			note_error($sformatf("register %0d reads %h, expected %h", idx, got, want));
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] ignored;
		reg_access(idx, 1'b1, value, ignored);
		case (idx)
			REG_DEBOUNCE: lockout_ticks = value[9:0];
			REG_FRAME: frame_len = value[15:0];
			REG_WIDTH1: code_width[0] = value[15:0];
			REG_WIDTH2: code_width[1] = value[15:0];
			REG_WIDTH3: code_width[2] = value[15:0];
			REG_WIDTH4: code_width[3] = value[15:0];
			default: ;
		endcase
		check_reg(idx, value);
	endtask

	task automatic set_config(input logic [31:0] db, input logic [31:0] frame,
			input logic [31:0] w1, input logic [31:0] w2, input logic [31:0] w3,
			input logic [31:0] w4);
		drain_drive();
		write_reg(REG_DEBOUNCE, db);
		write_reg(REG_FRAME, frame);
		write_reg(REG_WIDTH1, w1);
		write_reg(REG_WIDTH2, w2);
		write_reg(REG_WIDTH3, w3);
		write_reg(REG_WIDTH4, w4);
	endtask

	task automatic random_config();
		int unsigned f;
		logic [31:0] wd[4];
		f = $urandom_range(16, 1);
		foreach (wd[i]) begin
			wd[i] = ($urandom_range(7) == 0) ? 32'hFFFF : 32'($urandom_range(f + 3));
		end
		set_config(32'($urandom_range(4)), f, wd[0], wd[1], wd[2], wd[3]);
	endtask

	task automatic test_reset_values();
		check_reg(REG_DEBOUNCE, 32'(DEBOUNCE_RST));
		check_reg(REG_FRAME, 32'(FRAME_RST));
		check_reg(REG_WIDTH1, 32'(WIDTH1_RST));
		check_reg(REG_WIDTH2, 32'(WIDTH2_RST));
		check_reg(REG_WIDTH3, 32'(WIDTH3_RST));
		check_reg(REG_WIDTH4, 32'(WIDTH4_RST));
		// idle-high buttons show release edges on the first pass
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_LEFT));
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_GO));
		apply_pass(pressing(K_NONE));
	endtask

	task automatic test_directed_sequence();
		set_config(32'd1, 32'd6, 32'd0, 32'd3, 32'd6, 32'hFFFF);
		apply_pass(pressing(K_CLEAR));
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_LEFT));
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_RIGHT));
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_UP | K_DOWN));
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_LEFT | K_RIGHT | K_UP | K_DOWN));
		apply_pass(pressing(K_NONE));
		// two slots left for three presses, the last one is dropped
		apply_pass(pressing(K_LEFT | K_RIGHT | K_UP));
		// go switches to playback and the first frame follows its debounce span
		apply_pass(pressing(K_GO));
		repeat (10) apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_PAUSE | K_GO));
		apply_pass(pressing(K_CLEAR));
		// playback over an empty store gives no frames
		apply_pass(pressing(K_GO));
	endtask

	task automatic test_extreme_settings();
		set_config(32'd0, 32'd40, 32'hFFFF, 32'd0, 32'd1, 32'hFFFE);
		apply_pass(pressing(K_CLEAR));
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_LEFT));
		apply_pass(pressing(K_NONE));
		apply_pass(pressing(K_GO));
		apply_pass(pressing(K_NONE));
	endtask

	task automatic test_zero_frame();
		set_config(32'd0, 32'd0, 32'd5, 32'd5, 32'd5, 32'd5);
		run_random(150);
	endtask

	task automatic test_backpressure();
		random_config();
		hold_req = 1'b1;
		run_random(60);
	endtask

	task automatic test_random_settings();
		repeat (3) begin
			random_config();
			run_random(25);
		end
	endtask

	task automatic test_steady_stream();
		idling = 1'b0;
		random_config();
		run_random(60);
	endtask

	initial begin : drive_monitor
		out_t        want;
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && drive_valid && !drive_stall) begin
				if (drive_q.size() == 0) begin
					note_error($sformatf("unexpected drive word %s", drive_text(drive)));
				end else begin
					want = drive_q.pop_front();
					if (drive.pulse_out !== want.pulse_out || drive.playing !== want.playing ||
						drive.recorded_count !== want.recorded_count ||
						drive.played_count !== want.played_count) begin
						note_error($sformatf("drive expected %s, got %s", drive_text(want),
							drive_text(drive)));
					end
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				drive_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				drive_stall <= 1'b1;
			end else if (idling && $urandom_range(9) == 0) begin
				stall_left = $urandom_range(14);
				drive_stall <= 1'b1;
			end else begin
				drive_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		lockout_ticks = DEBOUNCE_RST;
		frame_len = FRAME_RST;
		code_width[0] = WIDTH1_RST;
		code_width[1] = WIDTH2_RST;
		code_width[2] = WIDTH3_RST;
		code_width[3] = WIDTH4_RST;
		foreach (cmd_store[i]) cmd_store[i] = CODE_NONE;
		rec_cnt = 0;
		play_cnt = 0;
		playback_mode = 1'b0;
		last_levels = '0;
		span_elapsed = 0;
		span_length = 0;
		high_from = 0;
		high_until = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_sequence();
		test_extreme_settings();
		test_zero_frame();
		test_backpressure();
		test_random_settings();
		test_steady_stream();

		drain_drive();
		repeat (4) @(posedge clk);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
